@@ design/mbg_pkg.sv @@
// Package for the maze carver: sequencer states, result kinds, register indexes.
// No dependencies.
package mbg_pkg;
  typedef enum logic [1:0] {
    KIND_PATH   = 2'd0,
    KIND_BACK   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_POP, S_POPWAIT, S_PROBE, S_PROBEWAIT, S_DECIDE,
    S_MARKW, S_MARKN, S_OUT0, S_OUT1
  } state_e;

  // choice mod count, count in 1..4
  function automatic logic [1:0] mod_count(input logic [7:0] c, input logic [2:0] n);
    logic [1:0] r;
    logic [3:0] s;
    logic [2:0] t;
    r = 2'd0;
    // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
    s = 4'(c[1:0]) + 4'(c[3:2]) + 4'(c[5:4]) + 4'(c[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    case (n)
      3'd2: r = {1'b0, c[0]};
      3'd3: r = t[1:0];
      3'd4: r = c[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction
endpackage

@@ design/mbg_visit_mem.sv @@
// Visited map: one bit per cell, one port, registered read.
// Depends on nothing.
module mbg_visit_mem #(
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     wdata_i,
  output logic                     rdata_o
);
  logic mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ design/mbg_stack_mem.sv @@
// Cell stack storage: one port, registered read.
// Depends on nothing.
module mbg_stack_mem #(
  parameter int Depth = 4096,
  parameter int Width = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ design/maze_backtracker_generator.sv @@
// Top level of the maze carver: sequencer, stack pointer and result register.
// Depends on mbg_pkg, mbg_visit_mem, mbg_stack_mem.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_stall_o | action, start_x, start_y, choice
//  out     | out | out_valid_o/out_stall_i | kind, cell_x, cell_y, last
//  cfg     | in  | cfg_we_i             | cfg_index_i, cfg_data_i
//
// Start: clearing sweep over every map entry (4096 at the default size), then
// mark and push of the start cell, one beat. Step: pop plus up to four
// visited-map probes, an in-range probe a read and a wait state, an
// out-of-range one only the probe state; then a backtrack beat from the decide
// state, or wall and cell marks then two carve beats; finished comes straight
// from idle. A waiting beat holds the input stalled and output stalls hold the
// sequencer. No clearing pass after reset is needed beyond the one every start
// performs; steps before any start see an empty stack.
module maze_backtracker_generator
  import mbg_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [5:0] start_x_i,
  input  logic [5:0] start_y_i,
  input  logic [7:0] choice_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [5:0] cell_x_o,
  output logic [5:0] cell_y_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int Cells = 1 << AW;

  logic [6:0] gw_q, gh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= 7'd31;
      gh_q <= 7'd31;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) gw_q <= cfg_data_i;
      else gh_q <= cfg_data_i;
    end
  end

  // effective size, saturated
  logic [8:0] w_eff, h_eff;
  always_comb begin
    w_eff = (gw_q < 7'd3) ? 9'd3 : ((9'(gw_q) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(gw_q));
    h_eff = (gh_q < 7'd3) ? 9'd3 : ((9'(gh_q) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(gh_q));
  end

  state_e state_q, state_d;
  logic [AW:0]   sp_q, sp_d;       // stack count
  logic [AW-1:0] clr_q, clr_d;
  logic [8:0]    cx_q, cx_d, cy_q, cy_d;
  logic [1:0]    dir_q, dir_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [1:0]    cand_q [4];
  logic [1:0]    cand_d [4];
  logic [7:0]    choice_q, choice_d;
  logic [8:0]    nx_q, nx_d, ny_q, ny_d;
  logic [8:0]    wx_q, wx_d, wy_q, wy_d;
  logic          pushc_q, pushc_d;
  logic [1:0]    kind_q, kind_d;
  logic [5:0]    ox_q, ox_d, oy_q, oy_d;
  logic          last_q, last_d, ov_q, ov_d;

  logic          vm_we, vm_wd, vm_rd;
  logic [AW-1:0] vm_addr;
  logic          sk_we;
  logic [AW-1:0] sk_addr;
  logic [AW-1:0] sk_wd, sk_rd;

  mbg_visit_mem #(.Depth(Cells)) u_vmem (
    .clk_i, .we_i(vm_we), .addr_i(vm_addr), .wdata_i(vm_wd), .rdata_o(vm_rd)
  );
  mbg_stack_mem #(.Depth(Cells), .Width(AW)) u_smem (
    .clk_i, .we_i(sk_we), .addr_i(sk_addr), .wdata_i(sk_wd), .rdata_o(sk_rd)
  );

  function automatic logic [AW-1:0] addr_of(input logic [8:0] x, input logic [8:0] y);
    return {y[YW-1:0], x[XW-1:0]};
  endfunction

  // probe target for the current direction
  logic [8:0] px, py;
  logic       p_in;
  always_comb begin
    px = cx_q;
    py = cy_q;
    case (dir_q)
      2'd0: py = cy_q + 9'd2;
      2'd1: px = cx_q + 9'd2;
      2'd2: py = cy_q - 9'd2;
      default: px = cx_q - 9'd2;
    endcase
    // unsigned wrap below zero yields a large value, failing the upper test
    p_in = (px != 9'd0) && (px < w_eff - 9'd1) && (py != 9'd0) && (py < h_eff - 9'd1);
  end

  // start alignment
  logic [8:0] sx, sy;
  always_comb begin
    sx = {3'd0, start_x_i};
    if (sx < 9'd1) sx = 9'd1;
    if (sx > w_eff - 9'd2) sx = w_eff - 9'd2;
    if (!sx[0]) sx = sx + 9'd1;
    sy = {3'd0, start_y_i};
    if (sy < 9'd1) sy = 9'd1;
    if (sy > h_eff - 9'd2) sy = h_eff - 9'd2;
    if (!sy[0]) sy = sy + 9'd1;
  end

  logic [1:0] pick;
  logic       full;
  assign full = (sp_q == (AW+1)'(Cells));

  always_comb begin
    state_d = state_q; sp_d = sp_q; clr_d = clr_q; cx_d = cx_q; cy_d = cy_q;
    dir_d = dir_q; cnt_d = cnt_q; cand_d = cand_q; choice_d = choice_q;
    nx_d = nx_q; ny_d = ny_q; wx_d = wx_q; wy_d = wy_q; pushc_d = pushc_q;
    kind_d = kind_q; ox_d = ox_q; oy_d = oy_q; last_d = last_q; ov_d = ov_q;
    vm_we = 1'b0; vm_wd = 1'b1; vm_addr = addr_of(cx_q, cy_q);
    sk_we = 1'b0; sk_addr = sp_q[AW-1:0]; sk_wd = addr_of(cx_q, cy_q);
    in_stall_o = 1'b1;
    pick = mod_count(choice_q, cnt_q);
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = ov_q;
        if (in_valid_i && !ov_q) begin
          choice_d = choice_i;
          if (!action_i) begin
            cx_d = sx; cy_d = sy; clr_d = '0;
            state_d = S_CLEAR;
          end else if (sp_q == '0) begin
            kind_d = KIND_FINISH; ox_d = '0; oy_d = '0; last_d = 1'b1; ov_d = 1'b1;
          end else begin
            sp_d = sp_q - 1'b1;
            state_d = S_POP;
          end
        end
      end
      S_CLEAR: begin
        vm_we = 1'b1; vm_wd = 1'b0; vm_addr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Cells - 1)) state_d = S_MARKN;
        nx_d = cx_q; ny_d = cy_q; sp_d = '0; pushc_d = 1'b0;
      end
      S_POP: begin
        sk_addr = sp_q[AW-1:0];
        state_d = S_POPWAIT;
      end
      S_POPWAIT: begin
        cx_d = {{(9-XW){1'b0}}, sk_rd[XW-1:0]};
        cy_d = {{(9-YW){1'b0}}, sk_rd[AW-1:XW]};
        dir_d = 2'd0; cnt_d = '0;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        vm_addr = addr_of(px, py);
        state_d = p_in ? S_PROBEWAIT : S_DECIDE;
        if (!p_in) begin
          dir_d = dir_q + 2'd1;
          if (dir_q != 2'd3) state_d = S_PROBE;
        end
      end
      S_PROBEWAIT: begin
        if (!vm_rd) begin
          cand_d[cnt_q[1:0]] = dir_q;
          cnt_d = cnt_q + 3'd1;
        end
        dir_d = dir_q + 2'd1;
        state_d = (dir_q == 2'd3) ? S_DECIDE : S_PROBE;
      end
      S_DECIDE: begin
        if (cnt_q == '0) begin
          kind_d = KIND_BACK; ox_d = cx_q[5:0]; oy_d = cy_q[5:0];
          last_d = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
        end else begin
          nx_d = cx_q; ny_d = cy_q; wx_d = cx_q; wy_d = cy_q;
          case (cand_q[pick])
            2'd0: begin ny_d = cy_q + 9'd2; wy_d = cy_q + 9'd1; end
            2'd1: begin nx_d = cx_q + 9'd2; wx_d = cx_q + 9'd1; end
            2'd2: begin ny_d = cy_q - 9'd2; wy_d = cy_q - 9'd1; end
            default: begin nx_d = cx_q - 9'd2; wx_d = cx_q - 9'd1; end
          endcase
          // re-push current cell
          sk_we = !full; sk_addr = sp_q[AW-1:0];
          if (!full) sp_d = sp_q + 1'b1;
          pushc_d = 1'b1;
          state_d = S_MARKW;
        end
      end
      S_MARKW: begin
        vm_we = 1'b1; vm_addr = addr_of(wx_q, wy_q);
        state_d = S_MARKN;
      end
      S_MARKN: begin
        vm_we = 1'b1; vm_addr = addr_of(nx_q, ny_q);
        sk_we = !full; sk_addr = sp_q[AW-1:0]; sk_wd = addr_of(nx_q, ny_q);
        if (!full) sp_d = sp_q + 1'b1;
        state_d = pushc_q ? S_OUT0 : S_OUT1;
      end
      S_OUT0: begin
        if (!ov_d) begin
          kind_d = KIND_PATH; ox_d = wx_q[5:0]; oy_d = wy_q[5:0];
          last_d = 1'b0; ov_d = 1'b1; state_d = S_OUT1;
        end
      end
      S_OUT1: begin
        if (!ov_d) begin
          kind_d = KIND_PATH; ox_d = nx_q[5:0]; oy_d = ny_q[5:0];
          last_d = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q <= clr_d; cx_q <= cx_d; cy_q <= cy_d; dir_q <= dir_d; cnt_q <= cnt_d;
    cand_q <= cand_d; choice_q <= choice_d; nx_q <= nx_d; ny_q <= ny_d;
    wx_q <= wx_d; wy_q <= wy_d; pushc_q <= pushc_d; kind_q <= kind_d;
    ox_q <= ox_d; oy_q <= oy_d; last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign cell_x_o    = ox_q;
  assign cell_y_o    = oy_q;
  assign last_o      = last_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE |-> cnt_q <= 3'd4) else $error("count");
  a_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= (AW+1)'(Cells)) else $error("stack overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(kind_q)) else $error("result lost");
endmodule

@@ tb/testbench.sv @@
// Testbench for maze_backtracker_generator: a scoreboard predicts every result beat
// and checks it against the block's output. Depends on mbg_pkg and the design files.
`timescale 1ns / 100ps

module testbench;
  import mbg_pkg::*;

  localparam int GRID_MAX   = 64;
  localparam int IDLE_LIMIT = 30000;

  typedef struct {
    kind_e      kind;
    logic [5:0] x;
    logic [5:0] y;
    logic       last;
  } carve_beat_t;

  typedef struct {
    int x;
    int y;
  } cell_t;

  class maze_scoreboard;
    int          grid_w = 31;
    int          grid_h = 31;
    bit          visited[GRID_MAX*GRID_MAX];
    cell_t       path_stack[$];
    carve_beat_t pending[$];
    int          errors = 0;

    function void push_beat(kind_e k, int x, int y, bit l);
      carve_beat_t b;
      b.kind = k;
      b.x    = 6'(x);
      b.y    = 6'(y);
      b.last = l;
      pending.push_back(b);
    endfunction

    function void note_input(logic act, logic [5:0] sx_in, logic [5:0] sy_in,
                             logic [7:0] ch);
      int    w, h, sx, sy, cnt, idx, nx, ny;
      int    dx[4] = '{0, 2, 0, -2};
      int    dy[4] = '{2, 0, -2, 0};
      cell_t cand[4];
      cell_t cur, c;
      w = (grid_w < 3) ? 3 : (grid_w > GRID_MAX) ? GRID_MAX : grid_w;
      h = (grid_h < 3) ? 3 : (grid_h > GRID_MAX) ? GRID_MAX : grid_h;
      if (act == 1'b0) begin
        sx = sx_in;
        sy = sy_in;
        if (sx < 1) sx = 1;
        if (sx > w - 2) sx = w - 2;
        if (sy < 1) sy = 1;
        if (sy > h - 2) sy = h - 2;
        if (sx % 2 == 0) sx++;
        if (sy % 2 == 0) sy++;
        foreach (visited[i]) visited[i] = 1'b0;
        path_stack.delete();
        visited[sx + GRID_MAX*sy] = 1'b1;
        cur.x = sx;
        cur.y = sy;
        path_stack.push_back(cur);
        push_beat(KIND_PATH, sx, sy, 1'b1);
        return;
      end
      if (path_stack.size() == 0) begin
        push_beat(KIND_FINISH, 0, 0, 1'b1);
        return;
      end
      cur = path_stack.pop_back();
      cnt = 0;
      for (int d = 0; d < 4; d++) begin
        nx = cur.x + dx[d];
        ny = cur.y + dy[d];
        if (nx > 0 && nx < w - 1 && ny > 0 && ny < h - 1 &&
            !visited[nx + GRID_MAX*ny]) begin
          cand[cnt].x = nx;
          cand[cnt].y = ny;
          cnt++;
        end
      end
      if (cnt == 0) begin
        push_beat(KIND_BACK, cur.x, cur.y, 1'b1);
        return;
      end
      path_stack.push_back(cur);
      idx = int'(ch) % cnt;
      c   = cand[idx];
      visited[(cur.x + c.x)/2 + GRID_MAX*((cur.y + c.y)/2)] = 1'b1;
      visited[c.x + GRID_MAX*c.y] = 1'b1;
      path_stack.push_back(c);
      push_beat(KIND_PATH, (cur.x + c.x)/2, (cur.y + c.y)/2, 1'b0);
      push_beat(KIND_PATH, c.x, c.y, 1'b1);
    endfunction

    function void check_result(logic [1:0] k, logic [5:0] x, logic [5:0] y, logic l);
      carve_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat kind=%0d x=%0d y=%0d", k, x, y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (x !== e.x) begin
        $error("cell_x: expected %0d, got %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("cell_y: expected %0d, got %0d", e.y, y);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       action_i;
  logic [5:0] start_x_i;
  logic [5:0] start_y_i;
  logic [7:0] choice_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [5:0] cell_x_o;
  logic [5:0] cell_y_o;
  logic       last_o;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [6:0] cfg_data_i;

  maze_backtracker_generator u_top (.*);

  maze_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;
  int quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stall; a requested hold-off is counted down here
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(kind_o, cell_x_o, cell_y_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_cmd(logic act, logic [5:0] sx, logic [5:0] sy, logic [7:0] ch);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    start_x_i  <= sx;
    start_y_i  <= sy;
    choice_i   <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(act, sx, sy, ch);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [6:0] w, logic [6:0] h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.grid_w = w;
    sb.grid_h = h;
  endtask

  task automatic rand_steps(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 2)
        send_cmd(1'b0, 6'($urandom), 6'($urandom), 8'($urandom));
      else
        send_cmd(1'b1, 6'($urandom), 6'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int w, h;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = 1'b0;
    start_x_i   = '0;
    start_y_i   = '0;
    choice_i    = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: step on empty stack, start clamping, odd alignment
    send_cmd(1'b1, 6'd0, 6'd0, 8'd0);
    send_cmd(1'b0, 6'd0, 6'd0, 8'd0);
    send_cmd(1'b1, 6'd0, 6'd0, 8'hff);
    send_cmd(1'b1, 6'd0, 6'd0, 8'd1);
    send_cmd(1'b0, 6'd63, 6'd63, 8'd0);
    send_cmd(1'b1, 6'd0, 6'd0, 8'd2);
    send_cmd(1'b0, 6'd4, 6'd10, 8'd0);
    send_cmd(1'b1, 6'd0, 6'd0, 8'd3);
    drain();
    // smallest grid: start, single cell, backtrack, finished
    write_grid(7'd0, 7'd0);
    send_cmd(1'b0, 6'd63, 6'd0, 8'd0);
    send_cmd(1'b1, 6'd0, 6'd0, 8'd0);
    send_cmd(1'b1, 6'd0, 6'd0, 8'd0);
    drain();
    // largest width register value and an even width landing start on last column
    write_grid(7'd127, 7'd64);
    send_cmd(1'b0, 6'd63, 6'd62, 8'd0);
    for (int i = 0; i < 6; i++) send_cmd(1'b1, 6'd0, 6'd0, 8'(i * 85));
    drain();
    write_grid(7'd5, 7'd5);
    send_cmd(1'b0, 6'd1, 6'd1, 8'd0);
    for (int i = 0; i < 8; i++) send_cmd(1'b1, 6'd0, 6'd0, 8'd7);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      if (ph == 3 || ph == 11) begin
        w = $urandom_range(127);
        h = $urandom_range(127);
      end else if (ph == 7) begin
        w = 64;
        h = 3;
      end else begin
        w = $urandom_range(3, 17);
        h = $urandom_range(3, 17);
      end
      write_grid(7'(w), 7'(h));
      // odd phases keep the old maze so the grid changes under carving
      if (ph % 2 == 0)
        send_cmd(1'b0, 6'($urandom), 6'($urandom), 8'($urandom));
      if (ph == 5) hold_cycles = 400;
      rand_steps(85);
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
